// ===== src/mslc_pkg.sv =====
// ----------------------------------------------------------------------------
// mslc_pkg
// Shared types and constants for the midpoint subdivision line clipper.
// ----------------------------------------------------------------------------
package mslc_pkg;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIN_LEFT   = 2'd0,
      CSR_WIN_RIGHT  = 2'd1,
      CSR_WIN_BOTTOM = 2'd2,
      CSR_WIN_TOP    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_POP    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // outcode bit positions
   localparam int OC_LEFT   = 0;
   localparam int OC_TOP    = 1;
   localparam int OC_RIGHT  = 2;
   localparam int OC_BOTTOM = 3;

endpackage

// ===== src/midpoint_subdivision_line_clipper_core.sv =====
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clipper_core
// Clips one segment against a window by midpoint subdivision.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one segment per transaction, two endpoints.
//  - Response channel (rsp_*): one transaction per segment; visible flag,
//    start of the first kept piece and end of the last kept piece (zero
//    when nothing is visible).
//  - CSR port (csr_*): window bounds, to be written by the user only while
//    the core is idle; the core itself does not enforce this.
//  - Every piece is evaluated in the evaluation state; every piece taken
//    back from the pending-piece stack first passes through the pop state
//    for the registered memory read.
//  - One segment at a time; the next request is taken in the cycle after
//    the response register is loaded, even if that response is still
//    waiting.
//  - A stalled response holds the response register; the core finishes
//    its current segment and then waits before loading the next result.
//  - Reset sets the window to the full coordinate range and empties the
//    response register. The stack memory needs no clearing.
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_clipper_core #(
   parameter int COORD_BITS  = 10,
   parameter int STACK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COORD_BITS-1:0]               req_start_x,
   input  logic [COORD_BITS-1:0]               req_start_y,
   input  logic [COORD_BITS-1:0]               req_end_x,
   input  logic [COORD_BITS-1:0]               req_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_visible,
   output logic [COORD_BITS-1:0]               rsp_clip_start_x,
   output logic [COORD_BITS-1:0]               rsp_clip_start_y,
   output logic [COORD_BITS-1:0]               rsp_clip_end_x,
   output logic [COORD_BITS-1:0]               rsp_clip_end_y,
   input  logic                                csr_wr_en,
   input  logic [mslc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]               csr_wdata
);
   import mslc_pkg::*;

   localparam int PIECE_W = 4 * COORD_BITS;
   localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W   = $clog2(STACK_DEPTH);

   // window
   logic [COORD_BITS-1:0] win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_right_ff  <= '1;
         win_bottom_ff <= '0;
         win_top_ff    <= '1;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WIN_LEFT:   win_left_ff   <= csr_wdata;
            CSR_WIN_RIGHT:  win_right_ff  <= csr_wdata;
            CSR_WIN_BOTTOM: win_bottom_ff <= csr_wdata;
            CSR_WIN_TOP:    win_top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and piece registers
   state_type             state_ff, state_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic                  found_ff, found_in;
   logic [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [COORD_BITS-1:0] ax_in, ay_in, bx_in, by_in;
   logic [COORD_BITS-1:0] fsx_ff, fsy_ff, lex_ff, ley_ff;
   logic [COORD_BITS-1:0] fsx_in, fsy_in, lex_in, ley_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_vis_ff, rsp_vis_in;
   logic [COORD_BITS-1:0] rsx_ff, rsy_ff, rex_ff, rey_ff;
   logic [COORD_BITS-1:0] rsx_in, rsy_in, rex_in, rey_in;

   // stack memory
   logic [PIECE_W-1:0]    stack_mem [STACK_DEPTH];
   logic [PIECE_W-1:0]    mem_rd_ff;
   logic                  push_en;
   logic [PIECE_W-1:0]    push_data;
   logic [IDX_W-1:0]      push_idx, pop_idx;
   logic [LVL_W-1:0]      level_dec;

   // piece evaluation
   logic [3:0]            ca, cb;
   logic [COORD_BITS:0]   sum_x, sum_y;
   logic [COORD_BITS-1:0] mx, my, dx, dy;
   logic                  short_piece, drop_piece, keep_piece, split_piece;
   logic                  out_free;

   always_comb begin
      ca[OC_LEFT]   = ax_ff < win_left_ff;
      ca[OC_TOP]    = ay_ff > win_top_ff;
      ca[OC_RIGHT]  = ax_ff > win_right_ff;
      ca[OC_BOTTOM] = ay_ff < win_bottom_ff;
      cb[OC_LEFT]   = bx_ff < win_left_ff;
      cb[OC_TOP]    = by_ff > win_top_ff;
      cb[OC_RIGHT]  = bx_ff > win_right_ff;
      cb[OC_BOTTOM] = by_ff < win_bottom_ff;
      sum_x = {1'b0, ax_ff} + {1'b0, bx_ff};
      sum_y = {1'b0, ay_ff} + {1'b0, by_ff};
      mx = sum_x[COORD_BITS:1];
      my = sum_y[COORD_BITS:1];
      dx = (ax_ff > bx_ff) ? ax_ff - bx_ff : bx_ff - ax_ff;
      dy = (ay_ff > by_ff) ? ay_ff - by_ff : by_ff - ay_ff;
      short_piece = (dx <= COORD_BITS'(1)) && (dy <= COORD_BITS'(1));
      drop_piece  = (ca & cb) != 4'd0;
      keep_piece  = !drop_piece &&
                    ((ca == 4'd0 && cb == 4'd0) || (short_piece && ca == 4'd0));
      split_piece = !drop_piece && !(ca == 4'd0 && cb == 4'd0) && !short_piece;
   end

   assign level_dec = level_ff - LVL_W'(1);
   assign push_idx  = level_ff[IDX_W-1:0];
   assign pop_idx   = level_dec[IDX_W-1:0];
   assign push_data = {by_ff, bx_ff, my, mx};
   assign push_en   = (state_ff == ST_EVAL) && split_piece &&
                      (level_ff < LVL_W'(STACK_DEPTH));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[push_idx] <= push_data;
      end
      mem_rd_ff <= stack_mem[pop_idx];
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      found_in     = found_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      fsx_in       = fsx_ff;
      fsy_in       = fsy_ff;
      lex_in       = lex_ff;
      ley_in       = ley_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vis_in   = rsp_vis_ff;
      rsx_in       = rsx_ff;
      rsy_in       = rsy_ff;
      rex_in       = rex_ff;
      rey_in       = rey_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ax_in    = req_start_x;
               ay_in    = req_start_y;
               bx_in    = req_end_x;
               by_in    = req_end_y;
               level_in = '0;
               found_in = 1'b0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (keep_piece) begin
               if (!found_ff) begin
                  fsx_in = ax_ff;
                  fsy_in = ay_ff;
               end
               found_in = 1'b1;
               lex_in   = bx_ff;
               ley_in   = by_ff;
            end
            if (split_piece) begin
               if (push_en) begin
                  level_in = level_ff + LVL_W'(1);
               end
               bx_in = mx;
               by_in = my;
            end else if (level_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               level_in = level_dec;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            ax_in    = mem_rd_ff[COORD_BITS-1:0];
            ay_in    = mem_rd_ff[2*COORD_BITS-1:COORD_BITS];
            bx_in    = mem_rd_ff[3*COORD_BITS-1:2*COORD_BITS];
            by_in    = mem_rd_ff[PIECE_W-1:3*COORD_BITS];
            state_in = ST_EVAL;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in   = found_ff;
               rsx_in       = found_ff ? fsx_ff : '0;
               rsy_in       = found_ff ? fsy_ff : '0;
               rex_in       = found_ff ? lex_ff : '0;
               rey_in       = found_ff ? ley_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      fsx_ff     <= fsx_in;
      fsy_ff     <= fsy_in;
      lex_ff     <= lex_in;
      ley_ff     <= ley_in;
      rsp_vis_ff <= rsp_vis_in;
      rsx_ff     <= rsx_in;
      rsy_ff     <= rsy_in;
      rex_ff     <= rex_in;
      rey_ff     <= rey_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visible      = rsp_vis_ff;
   assign rsp_clip_start_x = rsx_ff;
   assign rsp_clip_start_y = rsy_ff;
   assign rsp_clip_end_x   = rex_ff;
   assign rsp_clip_end_y   = rey_ff;

   // assertions
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_pop_after_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> $past(state_ff == ST_EVAL) && $past(level_ff) != '0)
      else $error("pop without a pending piece");

   a_fresh_segment: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EVAL && level_ff == '0 && !found_ff)
      else $error("segment started with stale state");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_clip_start_x == '0 && rsp_clip_start_y == '0 &&
                                    rsp_clip_end_x == '0 && rsp_clip_end_y == '0)
      else $error("hidden segment with nonzero coordinates");

endmodule

// ===== tb/sv/tb_midpoint_subdivision_line_clipper_core.sv =====
// ----------------------------------------------------------------------------
// tb_midpoint_subdivision_line_clipper_core
// Self-checking bench for the midpoint subdivision line clipper. A directed
// table covers full, clipped, point-sized and inverted windows. It is followed
// by random segments under a series of random windows. Every response is
// compared field by field against its table row or an in-bench clipping model.
// ----------------------------------------------------------------------------
module tb_midpoint_subdivision_line_clipper_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mslc_pkg::*;

   localparam int          CB          = 10;
   localparam int          STACK_SLOTS = 16;
   localparam int          PHASES      = 13;
   localparam int          PHASE_ITEMS = 100;
   localparam int unsigned RUN_LIMIT   = 2_000_000;

   typedef logic [CB-1:0] coord_type;
   localparam coord_type COORD_MAX = '1;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } piece_type;

   typedef struct packed {
      logic      visible;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } clip_result_type;

   typedef struct {
      int unsigned     id;
      clip_result_type res;
   } pending_clip_type;

   typedef enum logic {ROW_SEGMENT, ROW_WINDOW} row_kind_type;

   // window rows: a..d = left, right, bottom, top
   typedef struct {
      row_kind_type kind;
      bit           typed;
      int           a, b, c, d;
      bit           vis;
      int           sx, sy, ex, ey;
   } dir_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_start_x, req_start_y, req_end_x, req_end_y;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_visible;
   coord_type rsp_clip_start_x, rsp_clip_start_y, rsp_clip_end_x, rsp_clip_end_y;
   logic      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   coord_type csr_wdata;

   coord_type lim_left, lim_right, lim_bottom, lim_top;

   pending_clip_type outstanding[$];
   int unsigned      fail_count     = 0;
   int unsigned      cycle_count    = 0;
   int unsigned      segments_sent  = 0;
   int unsigned      windows_loaded = 0;
   int unsigned      visible_seen   = 0;
   int unsigned      burst_left     = 0;
   int unsigned      ready_hold     = 0;
   stall_mode_type   stall_mode     = STALL_NONE;

   dir_row_type directed_rows [24] = '{
      '{ROW_SEGMENT, 1,    0,    0, 1023, 1023, 1,    0,    0, 1023, 1023},
      '{ROW_SEGMENT, 1, 1023,    0,    0, 1023, 1, 1023,    0,    0, 1023},
      '{ROW_SEGMENT, 1,  512,  512,  512,  512, 1,  512,  512,  512,  512},
      '{ROW_WINDOW,  0,  100,  900,  200,  800, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1,    0,    0,   50,   50, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1,  950,  850, 1023, 1023, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1,  300,  300,  600,  600, 1,  300,  300,  600,  600},
      '{ROW_SEGMENT, 1,   99,  500,  100,  500, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1,  100,  500,   99,  500, 1,  100,  500,   99,  500},
      '{ROW_SEGMENT, 0,    0,  500, 1023,  500, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0,  500,    0,  500, 1023, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0,    0,    0, 1023, 1023, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0,   50,  500,  101,  500, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0,    0, 1023, 1023,    0, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0,    0,  850, 1023,  150, 0,    0,    0,    0,    0},
      '{ROW_WINDOW,  0,  900,  100,  800,  200, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1,  500,  500,  500,  500, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1,    0,    0, 1023, 1023, 0,    0,    0,    0,    0},
      '{ROW_WINDOW,  0, 1023, 1023,    0,    0, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 1, 1023,    0, 1023,    0, 1, 1023,    0, 1023,    0},
      '{ROW_SEGMENT, 0,    0,    0, 1023,    0, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0, 1023, 1023, 1023,    0, 0,    0,    0,    0,    0},
      '{ROW_WINDOW,  0,    0,    0,    0,    0, 0,    0,    0,    0,    0},
      '{ROW_SEGMENT, 0,    0,    0, 1023, 1023, 0,    0,    0,    0,    0}
   };

   midpoint_subdivision_line_clipper_core #(
      .COORD_BITS  (CB),
      .STACK_DEPTH (STACK_SLOTS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_visible      (rsp_visible),
      .rsp_clip_start_x (rsp_clip_start_x),
      .rsp_clip_start_y (rsp_clip_start_y),
      .rsp_clip_end_x   (rsp_clip_end_x),
      .rsp_clip_end_y   (rsp_clip_end_y),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   function automatic logic [3:0] region_code(input coord_type x, input coord_type y);
      logic [3:0] code;
      code = '0;
      code[OC_LEFT]   = (x < lim_left);
      code[OC_TOP]    = (y > lim_top);
      code[OC_RIGHT]  = (x > lim_right);
      code[OC_BOTTOM] = (y < lim_bottom);
      return code;
   endfunction

   function automatic coord_type span(input coord_type p, input coord_type q);
      return (p > q) ? p - q : q - p;
   endfunction

   function automatic clip_result_type clip_segment(input piece_type seg);
      piece_type       waiting [STACK_SLOTS];
      int              level;
      bit              busy;
      logic [3:0]      ca, cb;
      logic [CB:0]     sum_x, sum_y;
      piece_type       cur;
      clip_result_type r;
      cur   = seg;
      level = 0;
      busy  = 1'b1;
      r     = '0;
      while (busy) begin
         ca = region_code(cur.ax, cur.ay);
         cb = region_code(cur.bx, cur.by);
         if ((ca & cb) == 4'b0 && (ca | cb) != 4'b0 &&
             !(span(cur.ax, cur.bx) <= 1 && span(cur.ay, cur.by) <= 1)) begin
            sum_x = cur.ax + cur.bx;
            sum_y = cur.ay + cur.by;
            if (level < STACK_SLOTS) begin
               waiting[level] = '{sum_x[CB:1], sum_y[CB:1], cur.bx, cur.by};
               level++;
            end
            cur.bx = sum_x[CB:1];
            cur.by = sum_y[CB:1];
         end else begin
            // remaining cases keep the piece exactly when its start is inside
            if (ca == 4'b0) begin
               if (!r.visible) begin
                  r.visible = 1'b1;
                  r.start_x = cur.ax;
                  r.start_y = cur.ay;
               end
               r.end_x = cur.bx;
               r.end_y = cur.by;
            end
            if (level == 0) begin
               busy = 1'b0;
            end else begin
               level--;
               cur = waiting[level];
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic coord_type clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > int'(COORD_MAX)) return COORD_MAX;
      return coord_type'(v);
   endfunction

   function automatic coord_type near_bound(input coord_type lo, input coord_type hi);
      int base;
      base = $urandom_range(0, 1) ? int'(lo) : int'(hi);
      return clamp_coord(base + int'($urandom_range(0, 6)) - 3);
   endfunction

   function automatic coord_type pick_extreme(input coord_type lo, input coord_type hi);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return COORD_MAX;
         2:       return lo;
         default: return hi;
      endcase
   endfunction

   function automatic piece_type random_segment();
      piece_type s;
      s.ax = coord_type'($urandom);
      s.ay = coord_type'($urandom);
      s.bx = coord_type'($urandom);
      s.by = coord_type'($urandom);
      case ($urandom_range(0, 9))
         3, 4: begin
            s.ax = near_bound(lim_left, lim_right);
            s.ay = near_bound(lim_bottom, lim_top);
            s.bx = near_bound(lim_left, lim_right);
            s.by = near_bound(lim_bottom, lim_top);
         end
         5: begin
            s.ax = coord_type'($urandom_range(lim_right, lim_left));
            s.ay = coord_type'($urandom_range(lim_top, lim_bottom));
            s.bx = coord_type'($urandom_range(lim_right, lim_left));
            s.by = coord_type'($urandom_range(lim_top, lim_bottom));
         end
         6: begin
            s.ax = near_bound(lim_left, lim_right);
            s.ay = near_bound(lim_bottom, lim_top);
            s.bx = clamp_coord(int'(s.ax) + int'($urandom_range(0, 2)) - 1);
            s.by = clamp_coord(int'(s.ay) + int'($urandom_range(0, 2)) - 1);
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               s.ax = coord_type'($urandom_range(0, lim_left));
               s.bx = coord_type'($urandom_range(0, lim_left));
            end else begin
               s.ay = coord_type'($urandom_range(lim_top, COORD_MAX));
               s.by = coord_type'($urandom_range(lim_top, COORD_MAX));
            end
         end
         8: begin
            s.ax = pick_extreme(lim_left, lim_right);
            s.ay = pick_extreme(lim_bottom, lim_top);
            s.bx = pick_extreme(lim_left, lim_right);
            s.by = pick_extreme(lim_bottom, lim_top);
         end
         9: begin
            s.ax = coord_type'($urandom_range(0, lim_left));
            s.bx = coord_type'($urandom_range(lim_right, COORD_MAX));
            if ($urandom_range(0, 1)) begin
               s = '{s.bx, s.by, s.ax, s.ay};
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic pick_bounds(output coord_type lo, output coord_type hi);
      coord_type p, q;
      p = coord_type'($urandom);
      q = coord_type'($urandom);
      case ($urandom_range(0, 7))
         0: begin
            lo = '0;
            hi = COORD_MAX;
         end
         1: begin
            lo = $urandom_range(0, 1) ? COORD_MAX : '0;
            hi = lo;
         end
         2: begin
            lo = (p > q) ? p : q;
            hi = (p > q) ? q : p;
            if (lo == hi) lo = hi + 1'b1;
         end
         3: begin
            lo = p;
            hi = clamp_coord(int'(p) + int'($urandom_range(0, 8)));
         end
         default: begin
            lo = (p < q) ? p : q;
            hi = (p < q) ? q : p;
         end
      endcase
   endtask

   task automatic send_segment(input piece_type seg, input bit typed,
                               input clip_result_type want);
      pending_clip_type entry;
      int unsigned      gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 70);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_start_x = seg.ax;
      req_start_y = seg.ay;
      req_end_x   = seg.bx;
      req_end_y   = seg.by;
      req_valid   = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entry.id  = segments_sent;
      entry.res = typed ? want : clip_segment(seg);
      outstanding = {outstanding, entry};
      segments_sent++;
      burst_left--;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (outstanding.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_window(input coord_type l, input coord_type r, input coord_type b,
                                 input coord_type t);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_WIN_LEFT;
      csr_wdata = l;
      @(negedge clock);
      csr_index = CSR_WIN_RIGHT;
      csr_wdata = r;
      @(negedge clock);
      csr_index = CSR_WIN_BOTTOM;
      csr_wdata = b;
      @(negedge clock);
      csr_index = CSR_WIN_TOP;
      csr_wdata = t;
      @(negedge clock);
      csr_wr_en = 1'b0;
      lim_left   = l;
      lim_right  = r;
      lim_bottom = b;
      lim_top    = t;
      windows_loaded++;
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input int unsigned id, input string field,
                                  input int unsigned got, input int unsigned want);
      fail_count++;
      $display("mismatch on segment %0d: %s got %0d expected %0d", id, field, got, want);
   endtask

   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_ready <= 1'b1;
            STALL_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ready  <= !rsp_ready;
               ready_hold <= $urandom_range(0, 40);
            end
         endcase
      end
      if (cycle_count % 300 == 0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
   end

   always @(posedge clock) begin
      pending_clip_type e;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outstanding.size() == 0) begin
            report_mismatch(0, "response transaction with nothing outstanding", 1, 0);
         end else begin
            e = outstanding.pop_front();
            if (rsp_visible) visible_seen++;
            if (rsp_visible !== e.res.visible)
               report_mismatch(e.id, "visible", rsp_visible, e.res.visible);
            if (rsp_clip_start_x !== e.res.start_x)
               report_mismatch(e.id, "clip_start_x", rsp_clip_start_x, e.res.start_x);
            if (rsp_clip_start_y !== e.res.start_y)
               report_mismatch(e.id, "clip_start_y", rsp_clip_start_y, e.res.start_y);
            if (rsp_clip_end_x !== e.res.end_x)
               report_mismatch(e.id, "clip_end_x", rsp_clip_end_x, e.res.end_x);
            if (rsp_clip_end_y !== e.res.end_y)
               report_mismatch(e.id, "clip_end_y", rsp_clip_end_y, e.res.end_y);
         end
      end
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout with %0d transactions outstanding", outstanding.size());
         $display("midpoint_subdivision_line_clipper_core verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      dir_row_type     row;
      clip_result_type want;
      coord_type       l, r, b, t;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_WIN_LEFT;
      csr_wdata   = '0;
      lim_left    = '0;
      lim_right   = COORD_MAX;
      lim_bottom  = '0;
      lim_top     = COORD_MAX;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WINDOW) begin
            wait_idle();
            program_window(coord_type'(row.a), coord_type'(row.b), coord_type'(row.c),
                           coord_type'(row.d));
         end else begin
            want = '{row.vis, coord_type'(row.sx), coord_type'(row.sy), coord_type'(row.ex),
                     coord_type'(row.ey)};
            send_segment('{coord_type'(row.a), coord_type'(row.b), coord_type'(row.c),
                           coord_type'(row.d)},
                         row.typed, want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         pick_bounds(l, r);
         pick_bounds(b, t);
         program_window(l, r, b, t);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_segment(random_segment(), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("clipped %0d segments under %0d window settings", segments_sent, windows_loaded);
      $display("%0d segments came back visible, %0d mismatches", visible_seen, fail_count);
      if (fail_count == 0) begin
         $display("midpoint_subdivision_line_clipper_core verification clean");
      end else begin
         $display("midpoint_subdivision_line_clipper_core verification failed");
      end
      $finish;
   end

endmodule
